// ===== src/mmn_pkg.sv =====
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared types and constants for the min/max normalise-to-8-bit block.
// ----------------------------------------------------------------------------
`default_nettype none

package mmn_pkg;

    // widths of the fixed result fields
    localparam int PIX_W  = 8;
    localparam int IDX_W  = 14;

    // quotient of the stretch division is at most 255; the field is nine bits wide
    localparam int QUOT_W = 9;

    // clip mode: 255.0 in Q15.8, and half an lsb of the 8-bit result
    localparam int CLIP_HI  = 65280;
    localparam int CLIP_RND = 128;
    localparam int FRAC_W   = 8;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // command codes
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

    // drain sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PREP,
        ST_DIV
    } t_state;

endpackage

`default_nettype wire

// ===== src/mmn_store.sv =====
// ----------------------------------------------------------------------------
// mmn_store
// Sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmn_store #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14,
    parameter int DATA_W = 24
) (
    input  wire                i_clk,
    input  wire                i_wr_en,
    input  wire [ADDR_W-1:0]   i_wr_addr,
    input  wire [DATA_W-1:0]   i_wr_data,
    input  wire                i_rd_en,
    input  wire [ADDR_W-1:0]   i_rd_addr,
    output logic [DATA_W-1:0]  o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/mmn_div.sv =====
// ----------------------------------------------------------------------------
// mmn_div
// Restoring divider, one quotient bit per cycle, for quotients below 512.
// ----------------------------------------------------------------------------
`default_nettype none

module mmn_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 26
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [NUM_W-1:0]              i_num,
    input  wire [DEN_W-1:0]              i_den,
    output logic                         o_done,
    output logic [mmn_pkg::QUOT_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(mmn_pkg::QUOT_W);

    logic                        r_busy;
    logic [CNT_W-1:0]            r_cnt;
    logic [NUM_W-1:0]            r_rem;
    logic [NUM_W-1:0]            r_dsh;
    logic [NUM_W:0]              w_diff;
    logic                        w_ge;

    // trial subtraction of the shifted divisor
    assign w_diff = {1'b0, r_rem} - {1'b0, r_dsh};
    assign w_ge   = ~w_diff[NUM_W];

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(mmn_pkg::QUOT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    // remainder, divisor and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= NUM_W'(i_den) << (mmn_pkg::QUOT_W - 1);
            o_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_diff[NUM_W-1:0];
            end
            r_dsh  <= r_dsh >> 1;
            o_quot <= {o_quot[mmn_pkg::QUOT_W-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

// ===== src/minmax_normalize_to_8bit.sv =====
// ----------------------------------------------------------------------------
// minmax_normalize_to_8bit
// Frame store with min/max tracking and 8-bit contrast stretch or clip on drain.
// ----------------------------------------------------------------------------
// Usage:
// A command is taken at a clock edge where i_start is high and o_busy is low.
// i_cmd = load writes i_sample into the store and updates the running min and
// max; o_busy stays low during a load, so loads may be issued on every cycle.
// Loads beyond MAX_SAMPLES or once draining has begun are dropped. i_cmd = drain
// reads the next stored sample and converts it. o_busy is high, so no new
// command is taken, while it steps through ST_READ (store read), ST_PREP
// (form the dividend) and ST_DIV (one-bit-per-cycle divider, result register).
// The result is shown for one cycle with o_valid high, in the cycle o_busy
// falls; a new command may be taken at the edge that ends that cycle. A drain
// with nothing stored is accepted and gives no result. The result carrying
// o_last ends the frame. The receiver cannot hold results off; o_valid is a
// single-cycle strobe. Reset clears counters, min/max, the clip mode and
// o_valid; the store contents are left as they were. i_cfg_wr_en writes clip
// mode; the user must do so only while idle, as the block leaves it unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module minmax_normalize_to_8bit #(
    parameter int MAX_SAMPLES = 16384,
    parameter int SAMPLE_BITS = 24
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    output logic                               o_busy,
    input  wire                                i_cmd,
    input  wire signed [SAMPLE_BITS-1:0]       i_sample,
    input  wire                                i_cfg_wr_en,
    input  wire                                i_cfg_wr_data,
    output logic                               o_valid,
    output logic [mmn_pkg::PIX_W-1:0]          o_pixel,
    output logic [mmn_pkg::IDX_W-1:0]          o_sample_index,
    output logic                               o_last
);

    localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SPAN_W = SAMPLE_BITS + 1;
    localparam int NUM_W  = SAMPLE_BITS + 10;
    localparam int DEN_W  = SAMPLE_BITS + 2;
    localparam int CLIP_W = SAMPLE_BITS + 10;
    localparam logic signed [CLIP_W-1:0] CLIP_HI_W  = CLIP_W'(mmn_pkg::CLIP_HI);
    localparam logic signed [CLIP_W-1:0] CLIP_RND_W = CLIP_W'(mmn_pkg::CLIP_RND);

    mmn_pkg::t_state r_state, n_state;

    logic                           r_clip_mode;
    logic [CNT_W-1:0]               r_count;
    logic [ADDR_W-1:0]              r_rp;
    logic signed [SAMPLE_BITS-1:0]  r_min;
    logic signed [SAMPLE_BITS-1:0]  r_max;
    logic                           r_draining;
    logic                           r_is_last;

    logic [SPAN_W-1:0]              r_off;
    logic [SPAN_W-1:0]              r_span;
    logic                           r_flat;
    logic [mmn_pkg::PIX_W-1:0]      r_clip_pix;

    logic                           w_load;
    logic                           w_drain;
    logic                           w_rd_en;
    logic                           w_div_start;

    logic signed [SAMPLE_BITS-1:0]  w_rd_data;
    logic [NUM_W-1:0]               w_num;
    logic [DEN_W-1:0]               w_den;
    logic                           w_div_done;
    logic [mmn_pkg::QUOT_W-1:0]     w_quot;

    logic signed [CLIP_W-1:0]       w_x;
    logic signed [CLIP_W-1:0]       w_x_rnd;
    logic [mmn_pkg::PIX_W-1:0]      w_clip_pix;
    logic [mmn_pkg::PIX_W-1:0]      w_pix;
    logic [ADDR_W+mmn_pkg::IDX_W-1:0] w_idx_ext;

    // sample store
    mmn_store #(
        .DEPTH  (MAX_SAMPLES),
        .ADDR_W (ADDR_W),
        .DATA_W (SAMPLE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_load),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (i_sample),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rp),
        .o_rd_data (w_rd_data)
    );

    // stretch divider
    mmn_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and command decode
    always_comb begin
        n_state     = r_state;
        o_busy      = 1'b1;
        w_load      = 1'b0;
        w_drain     = 1'b0;
        w_rd_en     = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            mmn_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_cmd == mmn_pkg::CMD_LOAD) begin
                        w_load = !r_draining && (r_count < CNT_W'(MAX_SAMPLES));
                    end else if (r_count != '0) begin
                        w_drain = 1'b1;
                        w_rd_en = 1'b1;
                        n_state = mmn_pkg::ST_READ;
                    end
                end
            end
            mmn_pkg::ST_READ: begin
                n_state = mmn_pkg::ST_PREP;
            end
            mmn_pkg::ST_PREP: begin
                w_div_start = 1'b1;
                n_state     = mmn_pkg::ST_DIV;
            end
            mmn_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = mmn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mmn_pkg::ST_IDLE;
            end
        endcase
    end

    // clip conversion of the stored sample
    always_comb begin
        w_x     = CLIP_W'(w_rd_data);
        w_x_rnd = w_x + CLIP_RND_W;
        if (w_x[CLIP_W-1] || w_x == '0) begin
            w_clip_pix = '0;
        end else if (w_x >= CLIP_HI_W) begin
            w_clip_pix = mmn_pkg::PIX_MAX;
        end else begin
            w_clip_pix = w_x_rnd[mmn_pkg::FRAC_W +: mmn_pkg::PIX_W];
        end
    end

    // dividend (off * 510 + span) and divisor (2 * span)
    assign w_num = (NUM_W'(r_off) << 9) - (NUM_W'(r_off) << 1) + NUM_W'(r_span);
    assign w_den = DEN_W'(r_span) << 1;

    // final pixel selection
    always_comb begin
        if (r_clip_mode) begin
            w_pix = r_clip_pix;
        end else if (r_flat) begin
            w_pix = '0;
        end else if (w_quot[mmn_pkg::QUOT_W-1]) begin
            w_pix = mmn_pkg::PIX_MAX;
        end else begin
            w_pix = w_quot[mmn_pkg::PIX_W-1:0];
        end
    end

    assign w_idx_ext = {{mmn_pkg::IDX_W{1'b0}}, r_rp};

    // frame control: counters, min/max, draining flag, clip mode and o_valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_mode <= 1'b0;
            r_count     <= '0;
            r_rp        <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_draining  <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_wr_en) begin
                r_clip_mode <= i_cfg_wr_data;
            end
            if (w_load) begin
                r_count <= r_count + CNT_W'(1);
                if (r_count == '0) begin
                    r_min <= i_sample;
                    r_max <= i_sample;
                end else begin
                    if (i_sample < r_min) begin
                        r_min <= i_sample;
                    end
                    if (i_sample > r_max) begin
                        r_max <= i_sample;
                    end
                end
            end
            if (w_drain) begin
                r_draining <= 1'b1;
            end
            if (r_state == mmn_pkg::ST_DIV && w_div_done) begin
                o_valid <= 1'b1;
                if (r_is_last) begin
                    r_count    <= '0;
                    r_rp       <= '0;
                    r_min      <= '0;
                    r_max      <= '0;
                    r_draining <= 1'b0;
                end else begin
                    r_rp <= r_rp + ADDR_W'(1);
                end
            end
        end
    end

    // drain datapath and result registers
    always_ff @(posedge i_clk) begin
        if (w_drain) begin
            r_is_last <= (CNT_W'(r_rp) + CNT_W'(1)) == r_count;
        end
        if (r_state == mmn_pkg::ST_READ) begin
            r_off      <= SPAN_W'(w_rd_data) - SPAN_W'(r_min);
            r_span     <= SPAN_W'(r_max) - SPAN_W'(r_min);
            r_flat     <= (r_max == r_min);
            r_clip_pix <= w_clip_pix;
        end
        if (r_state == mmn_pkg::ST_DIV && w_div_done) begin
            o_pixel        <= w_pix;
            o_sample_index <= w_idx_ext[mmn_pkg::IDX_W-1:0];
            o_last         <= r_is_last;
        end
    end

endmodule

`default_nettype wire
